FILE: hdl/roct_pkg.sv
// roct_pkg: shared types and constants for the range odd count tree.
// Holds field widths, command codes and the request descriptor passed
// from the front classifier to the tree engine. No dependencies.
`timescale 1ns / 1ps

package roct_pkg;

   localparam int POS_W = 11;
   localparam int CNT_W = 11;
   localparam int VAL_W = 32;
   localparam int CMD_W = 2;

   localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_EVEN   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ODD    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RSVD   = 2'd3;

   typedef enum logic [1:0] {
      OP_UPDATE,
      OP_QUERY,
      OP_ZERO
   } op_kind_type;

   typedef struct packed {
      op_kind_type      kind;
      logic             odd;
      logic [POS_W-1:0] first;
      logic [POS_W-1:0] last;
      logic [POS_W-1:0] span;
      logic             bit_val;
   } op_type;

endpackage

FILE: hdl/range_odd_count_tree.sv
// range_odd_count_tree: top level; front classifier, op queue, tree engine
// and result queue. Depends on roct_pkg, roct_front, roct_fifo, roct_engine.
// Update: one level down per cycle to the leaf, then
//   a sibling read and parent write per level up through the node memory.
// Query: walks the tree with a node stack, summing covered nodes.
// After reset a clearing pass zeroes the node memory.
`timescale 1ns / 1ps

module range_odd_count_tree #(
   parameter int MAX_SIZE = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [roct_pkg::CMD_W-1:0]    req_cmd,
   input  logic [roct_pkg::POS_W-1:0]    req_first_pos,
   input  logic [roct_pkg::POS_W-1:0]    req_last_pos,
   input  logic [roct_pkg::VAL_W-1:0]    req_new_value,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [roct_pkg::CNT_W-1:0]    rsp_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [roct_pkg::POS_W-1:0]    csr_active_size
);

   localparam int OP_W = $bits(roct_pkg::op_type);

   roct_pkg::op_type           op_wdata, op_rdata;
   logic [OP_W-1:0]            op_rbits;
   logic                       op_push, op_full, op_pop, op_empty;
   logic                       res_push, res_full;
   logic [roct_pkg::CNT_W-1:0] res_data;

   assign op_rdata = roct_pkg::op_type'(op_rbits);

   roct_front #(.MAX_SIZE(MAX_SIZE)) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_active_size (csr_active_size),
      .req_push        (req_push),
      .req_cmd         (req_cmd),
      .req_first_pos   (req_first_pos),
      .req_last_pos    (req_last_pos),
      .req_new_value   (req_new_value),
      .op_full         (op_full),
      .req_full        (req_full),
      .op_push         (op_push),
      .op_data         (op_wdata)
   );

   roct_fifo #(.WIDTH(OP_W), .DEPTH(2)) u_op_q (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (OP_W'(op_wdata)),
      .full      (op_full),
      .pop       (op_pop),
      .pop_data  (op_rbits),
      .empty     (op_empty)
   );

   roct_engine #(.MAX_SIZE(MAX_SIZE)) u_engine (
      .clock    (clock),
      .reset    (reset),
      .op_empty (op_empty),
      .op_data  (op_rdata),
      .op_pop   (op_pop),
      .res_full (res_full),
      .res_push (res_push),
      .res_data (res_data)
   );

   roct_fifo #(.WIDTH(roct_pkg::CNT_W), .DEPTH(2)) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_count),
      .empty     (rsp_empty)
   );

endmodule

FILE: hdl/roct_fifo.sv
// roct_fifo: small register queue with push/pop and full/empty flags.
// Generic payload width; no package dependencies.
`timescale 1ns / 1ps

module roct_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW:0] DEPTH_CNT = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == DEPTH_CNT);
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/roct_front.sv
// roct_front: size register and request classifier; uses roct_pkg.
// Drops reserved commands and bad updates; the rest become ops.
`timescale 1ns / 1ps

module roct_front #(
   parameter int MAX_SIZE = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [roct_pkg::POS_W-1:0]    csr_active_size,
   input  logic                          req_push,
   input  logic [roct_pkg::CMD_W-1:0]    req_cmd,
   input  logic [roct_pkg::POS_W-1:0]    req_first_pos,
   input  logic [roct_pkg::POS_W-1:0]    req_last_pos,
   input  logic [roct_pkg::VAL_W-1:0]    req_new_value,
   input  logic                          op_full,
   output logic                          req_full,
   output logic                          op_push,
   output roct_pkg::op_type              op_data
);

   localparam logic [roct_pkg::POS_W-1:0] MAX_POS = roct_pkg::POS_W'(MAX_SIZE);

   logic [roct_pkg::POS_W-1:0] size_ff;
   logic [roct_pkg::POS_W-1:0] span;
   logic                       upd_ok, qry_bad, valid_cmd;

   assign csr_ready = 1'b1;
   assign req_full  = op_full;

   always_comb begin
      if (size_ff == '0) begin
         span = roct_pkg::POS_W'(1);
      end else if (32'(size_ff) > MAX_SIZE) begin
         span = MAX_POS;
      end else begin
         span = size_ff;
      end
      upd_ok  = (req_first_pos != '0) && (req_first_pos <= span);
      qry_bad = (req_first_pos == '0) || (req_last_pos > span) ||
                (req_first_pos > req_last_pos);
      op_data.odd     = (req_cmd == roct_pkg::CMD_ODD);
      op_data.first   = req_first_pos;
      op_data.last    = req_last_pos;
      op_data.span    = span;
      op_data.bit_val = req_new_value[0];
      valid_cmd       = 1'b1;
      case (req_cmd)
         roct_pkg::CMD_UPDATE: begin
            op_data.kind = roct_pkg::OP_UPDATE;
            valid_cmd    = upd_ok;
         end
         roct_pkg::CMD_EVEN, roct_pkg::CMD_ODD: begin
            op_data.kind = qry_bad ? roct_pkg::OP_ZERO : roct_pkg::OP_QUERY;
         end
         default: begin
            op_data.kind = roct_pkg::OP_ZERO;
            valid_cmd    = 1'b0;
         end
      endcase
      op_push = req_push && !op_full && valid_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= MAX_POS;
      end else if (csr_valid) begin
         size_ff <= csr_active_size;
      end
   end

endmodule

FILE: hdl/roct_engine.sv
// roct_engine: tree walker over the node count memory.
// Runs point updates and range sums one op at a time; uses roct_pkg.
`timescale 1ns / 1ps

module roct_engine #(
   parameter int MAX_SIZE = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       op_empty,
   input  roct_pkg::op_type           op_data,
   output logic                       op_pop,
   input  logic                       res_full,
   output logic                       res_push,
   output logic [roct_pkg::CNT_W-1:0] res_data
);

   localparam int LVL_W  = $clog2(MAX_SIZE);
   localparam int NODE_W = LVL_W + 2;
   localparam int NODES  = 4 * MAX_SIZE;
   localparam int STK_D  = 2 ** $clog2(LVL_W + 2);
   localparam int SP_W   = $clog2(STK_D) + 1;
   localparam int PW     = roct_pkg::POS_W;
   localparam int CW     = roct_pkg::CNT_W;
   localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);
   localparam logic [NODE_W-1:0] ROOT      = NODE_W'(1);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_U_DOWN, S_U_READ, S_U_WRITE, S_Q_WALK, S_Q_FIN, S_OUT
   } state_type;

   logic [CW-1:0]     mem [NODES];
   logic [CW-1:0]     rdata_ff;
   logic              mem_we, mem_re;
   logic [NODE_W-1:0] mem_waddr, mem_raddr;
   logic [CW-1:0]     mem_wdata;

   state_type         state_ff, state_in;
   roct_pkg::op_type  op_ff, op_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   logic [NODE_W-1:0] k_ff, k_in;
   logic [PW-1:0]     lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0]     val_ff, val_in, acc_ff, acc_in, res_ff, res_in;
   logic              pend_ff, pend_in;
   logic [SP_W-1:0]   sp_ff, sp_in;
   logic [NODE_W-1:0] stk_k_ff  [STK_D];
   logic [PW-1:0]     stk_lo_ff [STK_D];
   logic [PW-1:0]     stk_hi_ff [STK_D];

   logic              push_en, pop_node, covered, disjoint;
   logic [PW-1:0]     mid;
   logic [SP_W-1:0]   top;
   logic [NODE_W-1:0] parent, k_left;
   logic [CW-1:0]     total, len;

   assign res_data = res_ff;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      clr_in    = clr_ff;
      k_in      = k_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      val_in    = val_ff;
      acc_in    = acc_ff;
      res_in    = res_ff;
      pend_in   = pend_ff;
      sp_in     = sp_ff;
      op_pop    = 1'b0;
      res_push  = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = k_ff;
      mem_raddr = k_ff;
      mem_wdata = '0;
      push_en   = 1'b0;
      pop_node  = 1'b0;
      mid       = PW'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
      top       = sp_ff - 1'b1;
      parent    = k_ff >> 1;
      k_left    = {k_ff[NODE_W-2:0], 1'b0};
      covered   = (op_ff.first <= lo_ff) && (hi_ff <= op_ff.last);
      disjoint  = (op_ff.last < lo_ff) || (hi_ff < op_ff.first);
      total     = acc_ff + (pend_ff ? rdata_ff : '0);
      len       = op_ff.last - op_ff.first + 1'b1;
      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_NODE) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!op_empty) begin
               op_pop  = 1'b1;
               op_in   = op_data;
               k_in    = ROOT;
               lo_in   = PW'(1);
               hi_in   = op_data.span;
               sp_in   = '0;
               acc_in  = '0;
               pend_in = 1'b0;
               case (op_data.kind)
                  roct_pkg::OP_UPDATE: state_in = S_U_DOWN;
                  roct_pkg::OP_QUERY:  state_in = S_Q_WALK;
                  default: begin
                     res_in   = '0;
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_U_DOWN: begin
            if (lo_ff == hi_ff) begin
               mem_we    = 1'b1;
               mem_wdata = CW'(op_ff.bit_val);
               val_in    = CW'(op_ff.bit_val);
               state_in  = (k_ff == ROOT) ? S_IDLE : S_U_READ;
            end else if (op_ff.first <= mid) begin
               k_in  = k_left;
               hi_in = mid;
            end else begin
               k_in  = k_left | ROOT;
               lo_in = mid + 1'b1;
            end
         end
         S_U_READ: begin
            mem_re    = 1'b1;
            mem_raddr = k_ff ^ ROOT;
            state_in  = S_U_WRITE;
         end
         S_U_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = parent;
            mem_wdata = val_ff + rdata_ff;
            val_in    = val_ff + rdata_ff;
            k_in      = parent;
            state_in  = (parent == ROOT) ? S_IDLE : S_U_READ;
         end
         S_Q_WALK: begin
            acc_in  = total;
            pend_in = 1'b0;
            if (covered) begin
               mem_re   = 1'b1;
               pend_in  = 1'b1;
               pop_node = 1'b1;
            end else if (disjoint || (lo_ff == hi_ff)) begin
               pop_node = 1'b1;
            end else begin
               push_en = 1'b1;
               sp_in   = sp_ff + 1'b1;
               k_in    = k_left;
               hi_in   = mid;
            end
            if (pop_node) begin
               if (sp_ff == '0) begin
                  state_in = S_Q_FIN;
               end else begin
                  k_in  = stk_k_ff[top[SP_W-2:0]];
                  lo_in = stk_lo_ff[top[SP_W-2:0]];
                  hi_in = stk_hi_ff[top[SP_W-2:0]];
                  sp_in = top;
               end
            end
         end
         S_Q_FIN: begin
            pend_in  = 1'b0;
            res_in   = op_ff.odd ? total : len - total;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!res_full) begin
               res_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         sp_ff    <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         sp_ff    <= sp_in;
         pend_ff  <= pend_in;
      end
      op_ff  <= op_in;
      k_ff   <= k_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      val_ff <= val_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
      if (push_en) begin
         stk_k_ff[sp_ff[SP_W-2:0]]  <= k_left | ROOT;
         stk_lo_ff[sp_ff[SP_W-2:0]] <= mid + 1'b1;
         stk_hi_ff[sp_ff[SP_W-2:0]] <= hi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

endmodule

FILE: hdl/roct_checker.sv
// roct_checker: port-level assertions for range_odd_count_tree.
// Bound to the top level below; no package dependencies.
`timescale 1ns / 1ps

module roct_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [10:0] rsp_count
);

   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> rsp_empty)
      else $error("result waiting right after reset");

   a_open_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_full)
      else $error("request side full right after reset");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty)
      else $error("result dropped before pop");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> $stable(rsp_count))
      else $error("result changed before pop");

endmodule

bind range_odd_count_tree roct_checker u_roct_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_count (rsp_count)
);

FILE: sim/testbench.sv
// testbench: self-checking bench for range_odd_count_tree.
// Runs directed and random updates and range queries under several sizes
// and checks every count. Depends on roct_pkg and the range_odd_count_tree RTL.
`timescale 1ns / 1ps

class parity_scoreboard;
   localparam int SLOTS = 4096;
   bit [10:0] node_cnt [SLOTS];
   bit [10:0] size_reg;
   bit [10:0] count_q [$];
   int mismatches;

   function new();
      foreach (node_cnt[i]) node_cnt[i] = '0;
      size_reg = 11'd1024;
      mismatches = 0;
   endfunction

   function int span();
      if (size_reg < 1) return 1;
      if (size_reg > 1024) return 1024;
      return size_reg;
   endfunction

   function bit [10:0] rd(int k);
      return (k < SLOTS) ? node_cnt[k] : 11'd0;
   endfunction

   function void store(int k, int lo, int hi, int pos, bit b);
      int mid;
      if (k >= SLOTS) return;
      if (lo == hi) begin
         node_cnt[k] = 11'(b);
         return;
      end
      mid = (lo + hi) / 2;
      if (pos <= mid) store(2 * k, lo, mid, pos, b);
      else store(2 * k + 1, mid + 1, hi, pos, b);
      node_cnt[k] = rd(2 * k) + rd(2 * k + 1);
   endfunction

   function int odd_sum(int k, int lo, int hi, int from, int to);
      int mid;
      if (to < lo || hi < from) return 0;
      if (from <= lo && hi <= to) return rd(k);
      if (lo == hi || k >= SLOTS) return 0;
      mid = (lo + hi) / 2;
      return odd_sum(2 * k, lo, mid, from, to) + odd_sum(2 * k + 1, mid + 1, hi, from, to);
   endfunction

   function void note_request(bit [1:0] cmd, bit [10:0] f, bit [10:0] l, bit [31:0] v);
      int n;
      int odd;
      int res;
      n = span();
      if (cmd == roct_pkg::CMD_UPDATE) begin
         if (f >= 1 && f <= n) store(1, 1, n, f, v[0]);
         return;
      end
      if (cmd != roct_pkg::CMD_EVEN && cmd != roct_pkg::CMD_ODD) return;
      if (f < 1 || l > n || f > l) res = 0;
      else begin
         odd = odd_sum(1, 1, n, f, l);
         res = (cmd == roct_pkg::CMD_ODD) ? odd : (l - f + 1) - odd;
      end
      count_q.push_back(res[10:0]);
   endfunction

   function void check_count(bit [10:0] got);
      bit [10:0] want;
      if (count_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result: count=%0d", got);
         return;
      end
      want = count_q.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) $display("count mismatch: expected %0d actual %0d", want, got);
      end
   endfunction
endclass

module testbench;

   logic                       clock = 0;
   logic                       reset = 1;
   logic                       req_push = 0;
   logic                       req_full;
   logic [roct_pkg::CMD_W-1:0] req_cmd = '0;
   logic [roct_pkg::POS_W-1:0] req_first_pos = '0;
   logic [roct_pkg::POS_W-1:0] req_last_pos = '0;
   logic [roct_pkg::VAL_W-1:0] req_new_value = '0;
   logic                       rsp_empty;
   logic                       rsp_pop = 0;
   logic [roct_pkg::CNT_W-1:0] rsp_count;
   logic                       csr_valid = 0;
   logic                       csr_ready;
   logic [roct_pkg::POS_W-1:0] csr_active_size = '0;

   parity_scoreboard sb = new();
   int  cycles = 0;
   int  hold_left = 0;
   bit  hold_go = 0;
   bit  no_idle = 0;

   range_odd_count_tree uut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 1000000) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) sb.check_count(rsp_count);
      if (hold_go) begin
         hold_go = 0;
         hold_left = 600;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 0;
      end else if (reset) rsp_pop <= 0;
      else rsp_pop <= no_idle ? 1'b1 : ($urandom_range(99) >= 34);
   end

   task automatic send_request(bit [1:0] cmd, bit [10:0] f, bit [10:0] l, bit [31:0] v);
      while (!no_idle && $urandom_range(99) < 34) begin
         req_push <= 0;
         @(posedge clock);
      end
      req_push <= 1;
      req_cmd <= cmd;
      req_first_pos <= f;
      req_last_pos <= l;
      req_new_value <= v;
      do @(posedge clock); while (req_full);
      sb.note_request(cmd, f, l, v);
   endtask

   task automatic drain();
      req_push <= 0;
      @(posedge clock);
      while (sb.count_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_size(bit [10:0] s);
      csr_valid <= 1;
      csr_active_size <= s;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.size_reg = s;
   endtask

   function automatic bit [10:0] pick_pos(int n);
      if ($urandom_range(99) < 85) return 11'($urandom_range(n, 1));
      if ($urandom_range(1) == 0 || n >= 2047) return 11'd0;
      return 11'($urandom_range(2047, n + 1));
   endfunction

   task automatic random_phase(int items);
      int n;
      int r;
      bit [1:0] cmd;
      bit [10:0] f;
      bit [10:0] l;
      bit [10:0] t;
      n = sb.span();
      for (int i = 0; i < items; i++) begin
         r = $urandom_range(99);
         cmd = (r < 45) ? roct_pkg::CMD_UPDATE : (r < 70) ? roct_pkg::CMD_EVEN :
               (r < 95) ? roct_pkg::CMD_ODD : roct_pkg::CMD_RSVD;
         f = pick_pos(n);
         l = pick_pos(n);
         if (cmd != roct_pkg::CMD_UPDATE && $urandom_range(99) < 80 && f > l) begin
            t = f;
            f = l;
            l = t;
         end
         if ($urandom_range(99) < 3) l = 11'($urandom);
         send_request(cmd, f, l, $urandom);
      end
   endtask

   initial begin
      bit [10:0] sizes [10] = '{11'd1, 11'd0, 11'd2, 11'd7, 11'd100, 11'd2047,
                                11'd1000, 11'd513, 11'd1024, 11'd0};
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      write_size(11'd1024);

      send_request(roct_pkg::CMD_ODD, 1, 1024, 0);
      send_request(roct_pkg::CMD_EVEN, 1, 1024, 0);
      send_request(roct_pkg::CMD_UPDATE, 1, 0, 32'd1);
      send_request(roct_pkg::CMD_UPDATE, 1024, 2047, 32'h8000_0001);
      send_request(roct_pkg::CMD_UPDATE, 512, 0, 32'hFFFF_FFFF);
      send_request(roct_pkg::CMD_UPDATE, 0, 0, 32'd1);
      send_request(roct_pkg::CMD_UPDATE, 1025, 0, 32'd1);
      send_request(roct_pkg::CMD_UPDATE, 2047, 0, 32'd1);
      send_request(roct_pkg::CMD_ODD, 1, 1024, 0);
      send_request(roct_pkg::CMD_EVEN, 1, 1024, 0);
      send_request(roct_pkg::CMD_ODD, 10, 9, 0);
      send_request(roct_pkg::CMD_ODD, 0, 5, 0);
      send_request(roct_pkg::CMD_EVEN, 1, 1025, 0);
      send_request(roct_pkg::CMD_ODD, 1, 2047, 0);
      send_request(roct_pkg::CMD_ODD, 1024, 1024, 0);
      send_request(roct_pkg::CMD_EVEN, 2047, 2047, 0);
      send_request(roct_pkg::CMD_RSVD, 1, 1024, 32'd1);
      send_request(roct_pkg::CMD_UPDATE, 512, 0, 32'd2);
      send_request(roct_pkg::CMD_ODD, 1, 1024, 32'hFFFF_FFFE);
      send_request(roct_pkg::CMD_ODD, 512, 1024, 0);

      random_phase(100);
      hold_go = 1;
      no_idle = 1;
      random_phase(150);
      no_idle = 0;
      drain();
      random_phase(60);
      drain();

      foreach (sizes[i]) begin
         write_size(i == 9 ? 11'($urandom_range(1024, 3)) : sizes[i]);
         random_phase(i == 1 ? 40 : 115);
         drain();
      end
      write_size(11'd1024);
      random_phase(100);
      drain();

      if (sb.mismatches == 0 && sb.count_q.size() == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule

FILE: files.f
hdl/roct_pkg.sv
hdl/roct_fifo.sv
hdl/roct_front.sv
hdl/roct_engine.sv
hdl/range_odd_count_tree.sv
hdl/roct_checker.sv
sim/testbench.sv
